/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on rising edge, reset disables
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIDA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SIDA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/sida_pkg.sv */
// ----------------------------------------------------------------------------
// sida_pkg
// shared types and constants for the signed integer to decimal text block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sida_pkg;

  localparam int INT_W      = 32;
  localparam int CHAR_W     = 6;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CONV_STEPS = INT_W;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

/* design/sida_dabble_step.sv */
// ----------------------------------------------------------------------------
// sida_dabble_step
// one shift-and-add-3 step: corrects every bcd digit, then shifts in one bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sida_dabble_step (
  input  logic [sida_pkg::BCD_W-1:0] bcd,
  input  logic                       bit_in,
  output logic [sida_pkg::BCD_W-1:0] bcd_next
);

  logic [sida_pkg::BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < sida_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
    bcd_next = {adj[sida_pkg::BCD_W-2:0], bit_in};
  end

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a 32-bit two's complement integer to decimal ascii, msd first
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------
//  in      | in  | in_valid / in_stall | value[31:0] signed
//  out     | out | out_valid/out_stall | character[5:0], last
//
//  the magnitude goes through a single shift-and-add-3 unit, one bit per
//  cycle over all 32 bits; leading zero digits are then dropped one per cycle.
//  then the '-' sign (if negative) and the digits go out, each held while
//  out_stall is high; one beat per character.
//  in_stall is high after the input beat until the last character is taken,
//  so the next input beat can come in the cycle after the last output beat.
//  rst is synchronous and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [sida_pkg::INT_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sida_pkg::CHAR_W-1:0]   character,
  output logic                          last
);

  sida_pkg::state_t state, state_next;

  logic [sida_pkg::INT_W-1:0]  mag;
  logic [sida_pkg::BCD_W-1:0]  bcd;
  logic [sida_pkg::BCD_W-1:0]  bcd_step;
  logic [sida_pkg::CNT_W-1:0]  cnt;
  logic [sida_pkg::NDIG_W-1:0] ndig;
  logic                        neg;

  logic       in_beat;
  logic       out_beat;
  logic [3:0] top_digit;
  logic       at_last;

  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign top_digit = bcd[sida_pkg::BCD_W-1 -: 4];
  assign at_last   = (ndig == sida_pkg::NDIG_W'(1));

  sida_dabble_step u_step (
    .bcd      (bcd),
    .bit_in   (mag[sida_pkg::INT_W-1]),
    .bcd_next (bcd_step)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sida_pkg::ST_IDLE: begin
        if (in_beat) state_next = sida_pkg::ST_CONV;
      end
      sida_pkg::ST_CONV: begin
        if (cnt == sida_pkg::CNT_W'(sida_pkg::CONV_STEPS - 1)) begin
          state_next = sida_pkg::ST_SKIP;
        end
      end
      sida_pkg::ST_SKIP: begin
        if (top_digit != 4'd0 || at_last) begin
          state_next = neg ? sida_pkg::ST_SIGN : sida_pkg::ST_EMIT;
        end
      end
      sida_pkg::ST_SIGN: begin
        if (out_beat) state_next = sida_pkg::ST_EMIT;
      end
      sida_pkg::ST_EMIT: begin
        if (out_beat && at_last) state_next = sida_pkg::ST_IDLE;
      end
      default: state_next = sida_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    character = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(top_digit);
    last      = 1'b0;
    unique case (state)
      sida_pkg::ST_IDLE: in_stall = 1'b0;
      sida_pkg::ST_CONV, sida_pkg::ST_SKIP: ;
      sida_pkg::ST_SIGN: begin
        out_valid = 1'b1;
        character = sida_pkg::CHAR_MINUS;
      end
      sida_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        last      = at_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sida_pkg::ST_IDLE: begin
        if (in_beat) begin
          neg <= value[sida_pkg::INT_W-1];
          mag <= value[sida_pkg::INT_W-1] ? (sida_pkg::INT_W'(0) - value) : value;
          bcd <= '0;
          cnt <= '0;
        end
        ndig <= sida_pkg::NDIG_W'(sida_pkg::BCD_DIGITS);
      end
      sida_pkg::ST_CONV: begin
        bcd <= bcd_step;
        mag <= {mag[sida_pkg::INT_W-2:0], 1'b0};
        cnt <= cnt + sida_pkg::CNT_W'(1);
      end
      sida_pkg::ST_SKIP: begin
        // drop a leading zero digit
        if (top_digit == 4'd0 && !at_last) begin
          bcd  <= {bcd[sida_pkg::BCD_W-5:0], 4'd0};
          ndig <= ndig - sida_pkg::NDIG_W'(1);
        end
      end
      sida_pkg::ST_SIGN: ;
      sida_pkg::ST_EMIT: begin
        if (out_beat && !at_last) begin
          bcd  <= {bcd[sida_pkg::BCD_W-5:0], 4'd0};
          ndig <= ndig - sida_pkg::NDIG_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/sida_checker.sv */
// ----------------------------------------------------------------------------
// sida_checker
// port-level assertions for the decimal text converter, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sida_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sida_pkg::CHAR_W-1:0]   character,
  input logic                          last
);

  logic in_beat;
  logic out_wait;
  logic last_beat;
  logic char_ok;

  assign in_beat   = in_valid && !in_stall;
  assign out_wait  = out_valid && out_stall;
  assign last_beat = out_valid && !out_stall && last;
  assign char_ok   = (character == sida_pkg::CHAR_MINUS) ||
                     (character >= sida_pkg::CHAR_ZERO &&
                      character <= sida_pkg::CHAR_ZERO + 6'd9);

  // no new number taken while characters are still going out
  `SIDA_ASSERT_IMP(a_busy_while_out, clk, rst, out_valid, in_stall)

  // conversion takes cycles: no character right after an input beat
  `SIDA_ASSERT_NXT(a_no_out_after_in, clk, rst, in_beat, !out_valid)

  // a stalled output beat holds
  `SIDA_ASSERT_NXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(character) && $stable(last))

  // only '-' or a digit leaves
  `SIDA_ASSERT_IMP(a_char_range, clk, rst, out_valid, char_ok)

  // the last beat ends the run and frees the input
  `SIDA_ASSERT_NXT(a_last_ends, clk, rst, last_beat, !out_valid && !in_stall)

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
